>>> rtl/core/bugr_pkg.sv
// Shared types and constants for the bounded uniform and gaussian random block.
// No dependencies.
package bugr_pkg;

	localparam int unsigned TW_N = 624;
	localparam int unsigned TW_M = 397;
	localparam int unsigned SS_P = 306;
	localparam int unsigned SS_Q = 317;
	localparam int unsigned TW_AW = 10;

	localparam logic [31:0] FILL_WORD   = 32'h8b8b_8b8b;
	localparam logic [31:0] SEED_MUL_A  = 32'd1664525;
	localparam logic [31:0] SEED_MUL_B  = 32'd1566083941;
	localparam logic [31:0] TWIST_MAT   = 32'h9908_b0df;
	localparam logic [31:0] TEMPER_B    = 32'h9d2c_5680;
	localparam logic [31:0] TEMPER_C    = 32'hefc6_0000;
	localparam logic [31:0] TOP_BIT     = 32'h8000_0000;
	localparam logic [20:0] GAUSS_BIAS  = 21'd393210;
	localparam logic [3:0]  GAUSS_DRAWS = 4'd12;
	localparam logic [5:0]  DIV_STEPS   = 6'd33;

	localparam logic [7:0] REG_SEED   = 8'd0;
	localparam logic [7:0] REG_STREAM = 8'd1;

	localparam logic REQ_UNIFORM  = 1'b0;
	localparam logic REQ_GAUSSIAN = 1'b1;

	typedef enum logic [4:0] {
		ST_FILL, ST_SA, ST_SB, ST_SC, ST_SD, ST_SMUL, ST_SW1, ST_SW2, ST_SW3,
		ST_CKA, ST_CKB, ST_CKFIX, ST_IDLE, ST_DRAW, ST_DRAWW,
		ST_TA, ST_TB, ST_TC, ST_TD, ST_DIV, ST_GMUL, ST_GSHF, ST_GSAT, ST_DONE
	} bugr_state_t;

endpackage

>>> rtl/core/bounded_uniform_and_gaussian_rng.sv
// Top level of the bounded uniform and gaussian random block.
// Depends on bugr_pkg for state encoding and constants.
//
// Each input word is one request; each gives one result word unless a register
// write restarts seeding first. A Mersenne twister (624 x 32 state in one internal
// memory with one write port and one registered read port) is seeded from the seed
// and stream words by the seed sequence mixing pass. Seeding runs after reset and
// after each write to register 0 or 1 (a fill, 1248 mixing steps and a check); no
// request is taken meanwhile. One shared 33 x 33 multiplier serves the mixing and
// the gaussian scale, one shared restoring divider (one bit a cycle) serves the
// uniform range. A uniform request runs a divider pass for the limit, redraws any
// draw not below it and reduces the kept draw in a second pass; a gaussian request
// sums 12 draws. Every 624 draws a twist pass is inserted. Bad ranges and zero
// stdev go straight to the result. The memory read port sets the draw cost. A
// finished result is held in the output register while the next request runs.
module bounded_uniform_and_gaussian_rng (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [7:0]   cfg_index,
	input  logic [31:0]  cfg_wdata,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [127:0] s_tdata,   // lo_bound, hi_bound, mean, stdev
	input  logic         s_tuser,   // req_type
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [63:0]  m_tdata,   // uniform_value, gaussian_value
	output logic         m_tuser    // range_error
);
	import bugr_pkg::*;

	bugr_state_t state_q, state_d;

	logic [31:0] tw_mem [TW_N];
	logic [31:0] rd_q;
	logic [TW_AW-1:0] raddr, waddr;
	logic [31:0] wdata;
	logic        we;

	logic [31:0] seed_q, stream_q;
	logic [TW_AW-1:0] cnt_q, pos_q;
	logic        pass_q;
	logic        nz_q;
	logic [31:0] a_q, b_q, c_q, d_q;
	logic signed [65:0] prod_q;

	logic        type_q;
	logic [31:0] lo_q, n_q, mean_q, sd_q;
	logic [32:0] limit_q;
	logic [32:0] rem_q, dvd_q;
	logic [5:0]  dcnt_q;
	logic        dkind_q;
	logic [19:0] sum_q;
	logic [3:0]  gcnt_q;

	logic [31:0] res_u_q, res_g_q;
	logic        res_e_q;
	logic        m_valid_q;
	logic [63:0] m_data_q;
	logic        m_err_q;

	// ring index arithmetic
	logic [10:0] kp_w, kq_w, kn_w, km397_w;
	logic [TW_AW-1:0] kp, kq, k1, knext, k397;
	assign kp_w    = {1'b0, cnt_q} + 11'(SS_P);
	assign kq_w    = {1'b0, cnt_q} + 11'(SS_Q);
	assign km397_w = {1'b0, cnt_q} + 11'(TW_M);
	assign kn_w    = {1'b0, cnt_q} + 11'd1;
	assign kp    = (kp_w >= 11'(TW_N)) ? TW_AW'(kp_w - 11'(TW_N)) : kp_w[TW_AW-1:0];
	assign kq    = (kq_w >= 11'(TW_N)) ? TW_AW'(kq_w - 11'(TW_N)) : kq_w[TW_AW-1:0];
	assign k397  = (km397_w >= 11'(TW_N)) ? TW_AW'(km397_w - 11'(TW_N))
		: km397_w[TW_AW-1:0];
	assign knext = (kn_w >= 11'(TW_N)) ? '0 : kn_w[TW_AW-1:0];
	assign k1    = (cnt_q == '0) ? TW_AW'(TW_N - 1) : cnt_q - TW_AW'(1);

	logic last_k;
	assign last_k = (cnt_q == TW_AW'(TW_N - 1));

	// seeding arithmetic
	logic [31:0] mix_in, mix_v, r_lo, r2, r4, addend;
	assign mix_in = pass_q ? (a_q + b_q + c_q) : (a_q ^ b_q ^ c_q);
	assign mix_v  = mix_in ^ (mix_in >> 27);
	assign r_lo   = prod_q[31:0];
	always_comb begin
		if (cnt_q == '0) begin
			addend = 32'd2;
		end else if (cnt_q == TW_AW'(1)) begin
			addend = 32'd1 + seed_q;
		end else if (cnt_q == TW_AW'(2)) begin
			addend = 32'd2 + stream_q;
		end else begin
			addend = {{(32-TW_AW){1'b0}}, cnt_q};
		end
	end
	assign r2 = r_lo + addend;
	assign r4 = r_lo - {{(32-TW_AW){1'b0}}, cnt_q};

	// shared multiplier operands
	logic signed [32:0] mul_a, mul_b;
	logic signed [20:0] centered;
	assign centered = $signed({1'b0, sum_q}) - $signed(GAUSS_BIAS);
	always_comb begin
		if (state_q == ST_GMUL) begin
			mul_a = 33'(centered);
			mul_b = {sd_q[31], sd_q};
		end else begin
			mul_a = {1'b0, mix_v};
			mul_b = {1'b0, pass_q ? SEED_MUL_B : SEED_MUL_A};
		end
	end

	// tempering of the word read out
	logic [31:0] t1, t2, t3, tempered;
	assign t1 = rd_q ^ (rd_q >> 11);
	assign t2 = t1 ^ ((t1 << 7) & TEMPER_B);
	assign t3 = t2 ^ ((t2 << 15) & TEMPER_C);
	assign tempered = t3 ^ (t3 >> 18);

	// twist word
	logic [31:0] ty, tz;
	assign ty = (a_q & TOP_BIT) | (b_q & ~TOP_BIT);
	assign tz = rd_q ^ (ty >> 1) ^ (ty[0] ? TWIST_MAT : 32'd0);

	// divider step
	logic [32:0] rem_sh, rem_nx;
	assign rem_sh = {rem_q[31:0], dvd_q[32]};
	assign rem_nx = (rem_sh >= {1'b0, n_q}) ? rem_sh - {1'b0, n_q} : rem_sh;

	// gaussian finish
	logic signed [65:0] g_sum, g_lim_hi, g_lim_lo;
	logic [31:0] g_sat;
	assign g_sum    = 66'(signed'(mean_q)) + prod_q;
	assign g_lim_hi = 66'sd2147483647;
	assign g_lim_lo = -66'sd2147483648;
	assign g_sat = (g_sum > g_lim_hi) ? 32'h7fff_ffff
		: (g_sum < g_lim_lo) ? 32'h8000_0000 : g_sum[31:0];

	// request decode
	logic [31:0] in_lo, in_hi, in_mean, in_sd;
	logic        in_bad;
	assign in_lo   = s_tdata[31:0];
	assign in_hi   = s_tdata[63:32];
	assign in_mean = s_tdata[95:64];
	assign in_sd   = s_tdata[127:96];
	assign in_bad  = (in_lo > in_hi) || (in_lo == 32'd0 && in_hi == 32'hffff_ffff);

	logic cfg_hit, accept, out_free;
	assign cfg_hit  = cfg_we && (cfg_index == REG_SEED || cfg_index == REG_STREAM);
	assign s_tready = (state_q == ST_IDLE) && !cfg_hit;
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_valid_q || m_tready;

	// next state and memory port
	always_comb begin
		state_d = state_q;
		raddr   = cnt_q;
		waddr   = cnt_q;
		wdata   = FILL_WORD;
		we      = 1'b0;
		case (state_q)
			ST_FILL: begin
				we = 1'b1;
				if (last_k) state_d = ST_SA;
			end
			ST_SA: state_d = ST_SB;
			ST_SB: begin
				raddr = kp;
				state_d = ST_SC;
			end
			ST_SC: begin
				raddr = k1;
				state_d = ST_SD;
			end
			ST_SD: begin
				raddr = kq;
				state_d = ST_SMUL;
			end
			ST_SMUL: state_d = ST_SW1;
			ST_SW1: begin
				we = 1'b1;
				waddr = kp;
				wdata = pass_q ? (b_q ^ r_lo) : (b_q + r_lo);
				state_d = ST_SW2;
			end
			ST_SW2: begin
				we = 1'b1;
				waddr = kq;
				wdata = pass_q ? (d_q ^ r4) : (d_q + r2);
				state_d = ST_SW3;
			end
			ST_SW3: begin
				we = 1'b1;
				wdata = pass_q ? r4 : r2;
				if (last_k && pass_q) state_d = ST_CKA;
				else state_d = ST_SA;
			end
			ST_CKA: state_d = ST_CKB;
			ST_CKB: begin
				if (last_k) state_d = ST_CKFIX;
				else state_d = ST_CKA;
			end
			ST_CKFIX: begin
				waddr = '0;
				wdata = TOP_BIT;
				we = !nz_q;
				state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) begin
					if (s_tuser == REQ_UNIFORM) begin
						state_d = in_bad ? ST_DONE : ST_DIV;
					end else begin
						state_d = (in_sd == 32'd0) ? ST_DONE : ST_DRAW;
					end
				end
			end
			ST_DRAW: begin
				raddr = pos_q;
				if (pos_q == TW_AW'(TW_N)) state_d = ST_TA;
				else state_d = ST_DRAWW;
			end
			ST_DRAWW: begin
				if (type_q == REQ_UNIFORM) begin
					state_d = ({1'b0, tempered} >= limit_q) ? ST_DRAW : ST_DIV;
				end else begin
					state_d = (gcnt_q == GAUSS_DRAWS - 4'd1) ? ST_GMUL : ST_DRAW;
				end
			end
			ST_TA: state_d = ST_TB;
			ST_TB: begin
				raddr = knext;
				state_d = ST_TC;
			end
			ST_TC: begin
				raddr = k397;
				state_d = ST_TD;
			end
			ST_TD: begin
				we = 1'b1;
				wdata = tz;
				state_d = last_k ? ST_DRAW : ST_TA;
			end
			ST_DIV: begin
				if (dcnt_q == 6'd1) state_d = dkind_q ? ST_DONE : ST_DRAW;
			end
			ST_GMUL: state_d = ST_GSHF;
			ST_GSHF: state_d = ST_GSAT;
			ST_GSAT: state_d = ST_DONE;
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
		// a register write restarts seeding from any state
		if (cfg_hit) state_d = ST_FILL;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FILL;
		end else begin
			state_q <= state_d;
		end
	end

	// twister memory
	always_ff @(posedge clk) begin
		if (we) tw_mem[waddr] <= wdata;
		rd_q <= tw_mem[raddr];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q    <= '0;
			stream_q  <= '0;
			cnt_q     <= '0;
			pass_q    <= 1'b0;
			pos_q     <= TW_AW'(TW_N);
			m_valid_q <= 1'b0;
		end else begin
			// load a finished result, else drop the word once taken
			if (state_q == ST_DONE && out_free && !cfg_hit) m_valid_q <= 1'b1;
			else if (m_tready) m_valid_q <= 1'b0;
			if (cfg_hit) begin
				if (cfg_index == REG_SEED) seed_q <= cfg_wdata;
				else stream_q <= cfg_wdata;
				cnt_q  <= '0;
				pass_q <= 1'b0;
			end else begin
				case (state_q)
					ST_FILL: cnt_q <= last_k ? '0 : cnt_q + TW_AW'(1);
					ST_SW3: begin
						cnt_q <= last_k ? '0 : cnt_q + TW_AW'(1);
						if (last_k) pass_q <= 1'b1;
					end
					ST_CKB: cnt_q <= last_k ? '0 : cnt_q + TW_AW'(1);
					ST_CKFIX: begin
						pos_q  <= TW_AW'(TW_N);
						pass_q <= 1'b0;
					end
					ST_DRAWW: pos_q <= pos_q + TW_AW'(1);
					ST_TD: begin
						cnt_q <= last_k ? '0 : cnt_q + TW_AW'(1);
						if (last_k) pos_q <= '0;
					end
					default: ;
				endcase
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_SB, ST_TB: a_q <= rd_q;
			ST_SC, ST_TC: b_q <= rd_q;
			ST_SD: c_q <= rd_q;
			ST_SMUL: begin
				d_q    <= rd_q;
				prod_q <= mul_a * mul_b;
			end
			ST_SA: nz_q <= 1'b0;
			ST_CKB: begin
				if (cnt_q == '0) begin
					if (rd_q[31]) nz_q <= 1'b1;
				end else if (rd_q != 32'd0) begin
					nz_q <= 1'b1;
				end
			end
			ST_IDLE: begin
				type_q  <= s_tuser;
				lo_q    <= in_lo;
				n_q     <= in_hi - in_lo + 32'd1;
				mean_q  <= in_mean;
				sd_q    <= in_sd;
				sum_q   <= '0;
				gcnt_q  <= '0;
				res_u_q <= '0;
				res_g_q <= (s_tuser == REQ_GAUSSIAN) ? in_mean : 32'd0;
				res_e_q <= (s_tuser == REQ_UNIFORM) && in_bad;
				// first pass of the divider: 2^32 mod n
				rem_q   <= '0;
				dvd_q   <= 33'h1_0000_0000;
				dcnt_q  <= DIV_STEPS;
				dkind_q <= 1'b0;
			end
			ST_DRAWW: begin
				sum_q  <= sum_q + {4'd0, tempered[15:0]};
				gcnt_q <= gcnt_q + 4'd1;
				rem_q  <= '0;
				dvd_q  <= {1'b0, tempered};
				dcnt_q <= DIV_STEPS;
				dkind_q <= 1'b1;
			end
			ST_DIV: begin
				rem_q  <= rem_nx;
				dvd_q  <= {dvd_q[31:0], 1'b0};
				dcnt_q <= dcnt_q - 6'd1;
				if (dcnt_q == 6'd1) begin
					if (dkind_q) res_u_q <= lo_q + rem_nx[31:0];
					else limit_q <= 33'h1_0000_0000 - rem_nx;
				end
			end
			ST_GMUL: prod_q <= mul_a * mul_b;
			ST_GSHF: prod_q <= (prod_q + 66'sd32768) >>> 16;
			ST_GSAT: res_g_q <= g_sat;
			ST_DONE: begin
				if (out_free) begin
					m_data_q <= {res_g_q, res_u_q};
					m_err_q  <= res_e_q;
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_err_q;

endmodule
